// ===== design/rgbhsl_pkg.sv =====
`default_nettype none
package rgbhsl_pkg;
  localparam int MaxValue = 255;
  localparam int QuoW = 8;
  localparam int NumW = 16;
  localparam int DenW = 9;

  typedef struct packed {
    logic        vld;
    logic        grey;
    logic [7:0]  light;
    logic [NumW-1:0] s_rem;
    logic [DenW-1:0] s_den;
    logic [QuoW-1:0] s_quo;
    logic        h_neg;
    logic [NumW-1:0] h_rem;
    logic [DenW-1:0] h_den;
    logic [QuoW-1:0] h_quo;
    logic [2:0]  sector;
  } cell_t;
endpackage
`default_nettype wire

// ===== design/rgbhsl_cell.sv =====
`default_nettype none
module rgbhsl_cell (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire logic [3:0]          bit_idx,
  input  wire rgbhsl_pkg::cell_t   d_in,
  output rgbhsl_pkg::cell_t        d_out
);
  import rgbhsl_pkg::*;

  logic [NumW-1:0] s_trial;
  logic [NumW-1:0] h_trial;
  logic s_ge;
  logic h_ge;
  cell_t nxt;

  // one restoring quotient bit per cell for both dividers
  always_comb begin
    s_trial = NumW'({d_in.s_den, 7'b0}) >> (4'd7 - bit_idx);
    h_trial = NumW'({d_in.h_den, 7'b0}) >> (4'd7 - bit_idx);
    s_ge = d_in.s_rem >= s_trial;
    h_ge = d_in.h_rem >= h_trial;
    nxt = d_in;
    if (s_ge) begin
      nxt.s_rem = d_in.s_rem - s_trial;
    end
    if (h_ge) begin
      nxt.h_rem = d_in.h_rem - h_trial;
    end
    nxt.s_quo = d_in.s_quo | (QuoW'(s_ge) << bit_idx[2:0]);
    nxt.h_quo = d_in.h_quo | (QuoW'(h_ge) << bit_idx[2:0]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= nxt;
    end
  end
endmodule
`default_nettype wire

// ===== design/rgb_to_hsl_8bit.sv =====
`default_nettype none
// rgb to hsl converter, 0..255 scale
// in_tdata carries red, green, blue as 16-bit signed values, each clamped to 0..255.
// out_tdata carries hue, saturation, lightness as 8-bit values.
// cfg_tdata writes the saturation midpoint (reset 128); write only while idle.
// one item per clock unless the output stalls. twelve register stages: one
// front stage, eight divider cells (one quotient bit each for hue and
// saturation), one hue stage, one hue wrap stage and the output register.
// the whole chain advances only when the output register is free or taken,
// so a stalled receiver stops every stage and holds the result; in_tready
// follows out_tready or an empty output.
// synchronous active-low reset clears all valid flags and sets the midpoint to 128.
module rgb_to_hsl_8bit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // red_in, green_in, blue_in
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // hue_out, sat_out, light_out
  input  wire logic        cfg_tvalid,
  output logic             cfg_tready,
  input  wire logic [7:0]  cfg_tdata
);
  import rgbhsl_pkg::*;

  logic [7:0] mid_r;
  logic       en;
  logic [7:0] r, g, b, hi, lo;
  logic [8:0] sum;
  logic [7:0] spr;
  cell_t      front_nxt, front_r;
  cell_t      chain [0:QuoW];
  logic       h_vld_r, w_vld_r, out_vld_r;
  logic [11:0] h_r;
  logic       h_grey_r, w_grey_r;
  logic [7:0] h_l_r, h_s_r, w_l_r, w_s_r;
  logic [11:0] h_nxt;
  logic [10:0] h_mag;
  logic [20:0] h_prod;
  logic [7:0] h_q;
  logic [7:0] hw_r;
  logic [7:0] hw_nxt;
  logic [23:0] out_r;

  function automatic logic [7:0] clamp(input logic [15:0] v);
    if (v[15]) begin
      return 8'd0;
    end else if (v[14:8] != 7'd0) begin
      return 8'd255;
    end
    return v[7:0];
  endfunction

  assign en = !out_vld_r || out_tready;
  assign in_tready = en;
  assign cfg_tready = 1'b1;

  always_comb begin
    r = clamp(in_tdata[15:0]);
    g = clamp(in_tdata[31:16]);
    b = clamp(in_tdata[47:32]);
    hi = b;
    lo = b;
    if (r > hi) hi = r;
    if (g > hi) hi = g;
    if (r < lo) lo = r;
    if (g < lo) lo = g;
    sum = {1'b0, hi} + {1'b0, lo};
    spr = hi - lo;
    front_nxt = '0;
    front_nxt.vld = in_tvalid;
    front_nxt.grey = (hi == lo);
    front_nxt.light = sum[8:1];
    front_nxt.s_rem = NumW'(spr) * NumW'(MaxValue);
    front_nxt.s_den = (sum[8:1] < mid_r) ? sum : DenW'(2 * MaxValue) - sum;
    front_nxt.h_den = {1'b0, spr};
    if (r == hi) begin
      front_nxt.sector = 3'd0;
      front_nxt.h_neg = g < b;
      front_nxt.h_rem = NumW'((g < b) ? b - g : g - b) * NumW'(MaxValue);
    end else if (g == hi) begin
      front_nxt.sector = 3'd2;
      front_nxt.h_neg = b < r;
      front_nxt.h_rem = NumW'((b < r) ? r - b : b - r) * NumW'(MaxValue);
    end else begin
      front_nxt.sector = 3'd4;
      front_nxt.h_neg = r < g;
      front_nxt.h_rem = NumW'((r < g) ? g - r : r - g) * NumW'(MaxValue);
    end
    if (front_nxt.grey) begin
      front_nxt.s_den = 9'd1;
      front_nxt.h_den = 9'd1;
      front_nxt.s_rem = '0;
      front_nxt.h_rem = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_r <= 8'd128;
    end else if (cfg_tvalid && cfg_tready) begin
      mid_r <= cfg_tdata;
    end
    if (!rst_n) begin
      front_r.vld <= 1'b0;
    end else if (en) begin
      front_r <= front_nxt;
    end
  end

  assign chain[0] = front_r;

  for (genvar i = 0; i < QuoW; i++) begin : g_cell
    cell_t c_out;
    cell_t c_fix;
    rgbhsl_cell u_cell (
      .clk(clk), .en(en), .bit_idx(4'(QuoW - 1 - i)),
      .d_in(chain[i]), .d_out(c_out)
    );
    logic v_r;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (en) begin
        v_r <= chain[i].vld;
      end
    end
    always_comb begin
      c_fix = c_out;
      c_fix.vld = v_r;
    end
    assign chain[i+1] = c_fix;
  end

  // hue before /6: sector*255 +/- quotient, up to 1275
  always_comb begin
    h_nxt = 12'(chain[QuoW].sector) * 12'(MaxValue);
    if (chain[QuoW].h_neg) begin
      h_nxt = h_nxt - 12'(chain[QuoW].h_quo);
    end else begin
      h_nxt = h_nxt + 12'(chain[QuoW].h_quo);
    end
    // divide magnitude by 6 via *683 >> 12, exact below 2048
    h_mag = h_r[11] ? 11'(-h_r) : h_r[10:0];
    h_prod = 21'(h_mag) * 21'(683);
    h_q = h_prod[19:12];
    if (h_r[11] && h_q != 8'd0) begin
      hw_nxt = 8'(MaxValue) - h_q;
    end else begin
      hw_nxt = h_q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_vld_r <= 1'b0;
      w_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      h_vld_r <= chain[QuoW].vld;
      w_vld_r <= h_vld_r;
      out_vld_r <= w_vld_r;
    end
    if (en) begin
      h_r <= h_nxt;
      h_grey_r <= chain[QuoW].grey;
      h_l_r <= chain[QuoW].light;
      h_s_r <= chain[QuoW].s_quo;
      hw_r <= hw_nxt;
      w_grey_r <= h_grey_r;
      w_l_r <= h_l_r;
      w_s_r <= h_s_r;
      out_r <= w_grey_r ? {w_l_r, 16'd0} : {w_l_r, w_s_r, hw_r};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata = out_r;
endmodule
`default_nettype wire
